// ----- sv/double_free_tracker_table_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the double-free tracker table
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_FREE_TRACKER_TABLE_MACROS_SVH
`define DOUBLE_FREE_TRACKER_TABLE_MACROS_SVH

// Same-cycle implication
`define DFTT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define DFTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/dftt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dftt_pkg
// Types, codes and the status transition function of the tracker table.
// ----------------------------------------------------------------------------
package dftt_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int KEY_W             = 32;
	localparam int STATUS_W          = 2;

	// Event kinds
	localparam logic CMD_FREE   = 1'b0;
	localparam logic CMD_MALLOC = 1'b1;

	// Entry status codes
	localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FREED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic              lookup;
		logic              commit;
		logic              hit;
		logic [KEY_W-1:0]    key;
		logic [STATUS_W-1:0] next_status;
	} cell_ctrl_t;

	// What each cell shows to the controller
	typedef struct packed {
		logic              valid;
		logic              match;
		logic [STATUS_W-1:0] status;
	} cell_stat_t;

	// Next status for a tracked entry; an unknown code behaves as error
	function automatic logic [STATUS_W-1:0] next_status_f(
		input logic [STATUS_W-1:0] cur,
		input logic                cmd
	);
		logic [STATUS_W-1:0] nxt;
		case (cur)
			ST_ALLOC: nxt = (cmd == CMD_MALLOC) ? ST_ALLOC : ST_FREED;
			ST_FREED: nxt = (cmd == CMD_MALLOC) ? ST_ALLOC : ST_ERROR;
			default:  nxt = ST_ERROR;
		endcase
		return nxt;
	endfunction

endpackage
`default_nettype wire

// ----- sv/dftt_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dftt_req_if
// Event channel: one malloc or free item per handshake.
// ----------------------------------------------------------------------------
interface dftt_req_if;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [dftt_pkg::KEY_W-1:0] object_key;

	modport source (output valid, output cmd, output object_key, input ready);
	modport sink   (input valid, input cmd, input object_key, output ready);
endinterface
`default_nettype wire

// ----- sv/dftt_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dftt_rsp_if
// Result channel: entry status and flags, one item per event.
// ----------------------------------------------------------------------------
interface dftt_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [dftt_pkg::STATUS_W-1:0] new_status;
	logic                         was_tracked;
	logic                         error_flag;
	logic                         table_full;

	modport source (output valid, output new_status, output was_tracked,
		output error_flag, output table_full, input ready);
	modport sink   (input valid, input new_status, input was_tracked,
		input error_flag, input table_full, output ready);
endinterface
`default_nettype wire

// ----- sv/dftt_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dftt_cell
// One table slot: valid flag, key and status, with its own key compare.
// Slots fill in order; a slot claims an insert only when its left neighbor
// is already valid, so the valid flags form a thermometer along the row.
// ----------------------------------------------------------------------------
module dftt_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  dftt_pkg::cell_ctrl_t ctrl,
	input  wire                  prev_valid,
	output dftt_pkg::cell_stat_t stat
);
	import dftt_pkg::*;

	logic                valid_q;
	logic [KEY_W-1:0]    key_q;
	logic [STATUS_W-1:0] status_q;
	logic                match_s1;
	logic                insert;

	// claim the insert if this is the first empty slot on a miss
	assign insert = ctrl.commit && !ctrl.hit && prev_valid && !valid_q;

	// hold valid flag and registered compare result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			match_s1 <= 1'b0;
		end else begin
			if (insert) begin
				valid_q <= 1'b1;
			end
			if (ctrl.lookup) begin
				match_s1 <= valid_q && (key_q == ctrl.key);
			end
		end
	end

	// update status on a hit, load key and status on an insert
	always_ff @(posedge clk) begin
		if (ctrl.commit && match_s1) begin
			status_q <= ctrl.next_status;
		end else if (insert) begin
			key_q    <= ctrl.key;
			status_q <= ST_ALLOC;
		end
	end

	assign stat.valid  = valid_q;
	assign stat.match  = match_s1;
	assign stat.status = status_q;

endmodule
`default_nettype wire

// ----- sv/double_free_tracker_table.sv -----
`default_nettype none
// Flow: one event at a time (accept, compare in all cells, update): the
// accepted event is registered, then the result register on rsp is written;
// a new event is taken while the previous result still waits.
// The update stalls only while the result register is still full.
// Reset: arst_n clears all slot valid flags and the control; no sweep needed.
// ----------------------------------------------------------------------------
// double_free_tracker_table
// Tracks malloc/free events per object key in a row of slot cells and
// reports each entry's allocated/freed/error status.
// ----------------------------------------------------------------------------
module double_free_tracker_table #(
	parameter int TABLE_ENTRIES = dftt_pkg::TABLE_ENTRIES_DEF
) (
	input wire         clk,
	input wire         arst_n,
	dftt_req_if.sink   req,
	dftt_rsp_if.source rsp
);
	import dftt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_LOOKUP = 3'b010,
		S_UPDATE = 3'b100
	} state_t;

	state_t              state_q;
	logic                cmd_q;
	logic [KEY_W-1:0]    key_q;
	cell_ctrl_t          ctrl;
	cell_stat_t          stat [TABLE_ENTRIES];
	logic                hit;
	logic [STATUS_W-1:0] cur_status;
	logic [STATUS_W-1:0] nxt_status;
	logic                full;
	logic                commit;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] new_status_q;
	logic                was_tracked_q;
	logic                error_flag_q;
	logic                table_full_q;
	logic [STATUS_W-1:0] res_status;
	logic                res_full;

	assign req.ready = (state_q == S_IDLE);
	assign commit    = (state_q == S_UPDATE) && (!rsp_valid_q || rsp.ready);

	// sequence one event: accept, compare, update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the accepted event
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q <= req.cmd;
			key_q <= req.object_key;
		end
	end

	// gather the matching cell's status; keys are unique, so at most one hits
	always_comb begin
		hit        = 1'b0;
		cur_status = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit        = hit | stat[i].match;
			cur_status = cur_status | (stat[i].status & {STATUS_W{stat[i].match}});
		end
	end

	assign nxt_status = next_status_f(cur_status, cmd_q);
	assign full       = stat[TABLE_ENTRIES-1].valid;

	assign ctrl.lookup      = (state_q == S_LOOKUP);
	assign ctrl.commit      = commit;
	assign ctrl.hit         = hit;
	assign ctrl.key         = key_q;
	assign ctrl.next_status = nxt_status;

	// row of slot cells, each fed its left neighbor's valid flag
	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		if (g == 0) begin : g_head
			dftt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.prev_valid (1'b1),
				.stat       (stat[g])
			);
		end else begin : g_body
			dftt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.prev_valid (stat[g-1].valid),
				.stat       (stat[g])
			);
		end
	end

	// form the result: hit steps the status, miss inserts or reports full
	assign res_status = hit ? nxt_status : ST_ALLOC;
	assign res_full   = !hit && full;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			new_status_q  <= res_status;
			was_tracked_q <= hit;
			error_flag_q  <= (res_status == ST_ERROR);
			table_full_q  <= res_full;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.new_status  = new_status_q;
	assign rsp.was_tracked = was_tracked_q;
	assign rsp.error_flag  = error_flag_q;
	assign rsp.table_full  = table_full_q;

endmodule
`default_nettype wire

// ----- sv/dftt_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dftt_checker
// Port-level checks of the tracker table, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_free_tracker_table_macros.svh"

module dftt_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          req_valid,
	input wire                          req_ready,
	input wire                          rsp_valid,
	input wire                          rsp_ready,
	input wire [dftt_pkg::STATUS_W-1:0] new_status,
	input wire                          was_tracked,
	input wire                          error_flag,
	input wire                          table_full
);
	import dftt_pkg::*;

	// error flag follows the reported status
	`DFTT_ASSERT_SAME(a_err_flag, rsp_valid, error_flag == (new_status == ST_ERROR), "error_flag mismatch")

	// a full-table result carries no tracked entry and reports allocated
	`DFTT_ASSERT_SAME(a_full_res, rsp_valid && table_full, !was_tracked && (new_status == ST_ALLOC), "table_full result malformed")

	// one event in flight: no accept in the cycle after an accept
	`DFTT_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "back-to-back accept")

	// a stalled result holds
	`DFTT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(new_status) && $stable(was_tracked) && $stable(table_full), "stalled result changed")

endmodule

bind double_free_tracker_table dftt_checker u_dftt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.new_status  (rsp.new_status),
	.was_tracked (rsp.was_tracked),
	.error_flag  (rsp.error_flag),
	.table_full  (rsp.table_full)
);
`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-free tracker table. A driver pushes
// malloc/free items from a pending queue and predicts each result at the
// accept edge. A monitor compares every result with the oldest prediction.
// Stimulus: a short directed run over extreme keys and status transitions,
// then random traffic. Most random items come from a small key pool in
// alternating malloc/free pairs. Fresh keys follow until the table fills.
// ----------------------------------------------------------------------------
module tb_top;
	import dftt_pkg::*;

	localparam int N_SLOTS     = TABLE_ENTRIES_DEF;
	localparam int POOL_KEYS   = 40;
	localparam int N_RANDOM    = 1230;
	localparam int N_POOL_ONLY = 600;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_FROM  = 700;
	localparam int QUIET_TO    = 900;
	localparam int DRAIN       = 10;

	// Next entry status, indexed by current status
	localparam logic [STATUS_W-1:0] NEXT_ON_FREE[4] =
		'{ST_FREED, ST_ERROR, ST_ERROR, ST_ERROR};
	localparam logic [STATUS_W-1:0] NEXT_ON_MALLOC[4] =
		'{ST_ALLOC, ST_ALLOC, ST_ERROR, ST_ERROR};

	typedef struct packed {
		logic             cmd;
		logic [KEY_W-1:0] key;
	} tracker_event_t;

	typedef struct packed {
		logic [STATUS_W-1:0] new_status;
		logic                was_tracked;
		logic                error_flag;
		logic                table_full;
	} status_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dftt_req_if req_ch ();
	dftt_rsp_if rsp_ch ();

	double_free_tracker_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	tracker_event_t pending_events[$];
	status_report_t expected_reports[$];

	// Shadow of the slot table
	logic                slot_used[N_SLOTS];
	logic [KEY_W-1:0]    slot_key[N_SLOTS];
	logic [STATUS_W-1:0] slot_state[N_SLOTS];

	int n_sent = 0;
	int err_count = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	// Clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		err_count++;
	endtask

	task automatic add_event(input logic cmd, input logic [KEY_W-1:0] key);
		tracker_event_t ev;
		ev.cmd = cmd;
		ev.key = key;
		pending_events.push_back(ev);
	endtask

	// Look up the key, step or insert its entry, and return the report
	function automatic status_report_t track_event(input logic cmd,
		input logic [KEY_W-1:0] key);
		status_report_t rep;
		int hit;
		int spare;
		rep.new_status  = ST_ALLOC;
		rep.was_tracked = 1'b0;
		rep.error_flag  = 1'b0;
		rep.table_full  = 1'b0;
		hit = -1;
		spare = -1;
		for (int i = 0; i < N_SLOTS; i++) begin
			if (slot_used[i]) begin
				if (hit < 0 && slot_key[i] == key)
					hit = i;
			end else if (spare < 0) begin
				spare = i;
			end
		end
		if (hit >= 0) begin
			rep.new_status = (cmd == CMD_MALLOC) ? NEXT_ON_MALLOC[slot_state[hit]]
				: NEXT_ON_FREE[slot_state[hit]];
			slot_state[hit] = rep.new_status;
			rep.was_tracked = 1'b1;
			rep.error_flag  = (rep.new_status == ST_ERROR);
		end else if (spare >= 0) begin
			slot_used[spare]  = 1'b1;
			slot_key[spare]   = key;
			slot_state[spare] = ST_ALLOC;
		end else begin
			rep.table_full = 1'b1;
		end
		return rep;
	endfunction

	function automatic bit quiet_phase();
		return n_sent >= QUIET_FROM && n_sent < QUIET_TO;
	endfunction

	// Driver: predict on accept, then offer the next pending item
	always @(posedge clk) begin
		tracker_event_t ev;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				expected_reports.push_back(track_event(req_ch.cmd, req_ch.object_key));
				n_sent++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_events.size() != 0
					&& (quiet_phase() || $urandom_range(99) >= 20)) begin
					ev = pending_events.pop_front();
					req_ch.valid      <= 1'b1;
					req_ch.cmd        <= ev.cmd;
					req_ch.object_key <= ev.key;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, once, partway through the run
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0)
				hold_left <= hold_left - 1;
			else if (!hold_done && n_sent >= HOLD_AT) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end
		end
	end

	// Monitor: compare each result with the oldest prediction
	always @(posedge clk) begin
		status_report_t exp;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_reports.size() == 0) begin
					flag_error("result with no pending event");
				end else begin
					exp = expected_reports.pop_front();
					if (rsp_ch.new_status !== exp.new_status)
						flag_error($sformatf("new_status got %0d exp %0d",
							rsp_ch.new_status, exp.new_status));
					if (rsp_ch.was_tracked !== exp.was_tracked)
						flag_error($sformatf("was_tracked got %0d exp %0d",
							rsp_ch.was_tracked, exp.was_tracked));
					if (rsp_ch.error_flag !== exp.error_flag)
						flag_error($sformatf("error_flag got %0d exp %0d",
							rsp_ch.error_flag, exp.error_flag));
					if (rsp_ch.table_full !== exp.table_full)
						flag_error($sformatf("table_full got %0d exp %0d",
							rsp_ch.table_full, exp.table_full));
				end
			end
			rsp_ch.ready <= (hold_left == 0) && (quiet_phase() || $urandom_range(99) >= 20);
		end
	end

	// Timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Stimulus, reset and end of run
	initial begin
		logic [KEY_W-1:0] pool_key[POOL_KEYS];
		bit               pool_last[POOL_KEYS];
		int               idx;
		logic             cmd;

		req_ch.valid      = 1'b0;
		req_ch.cmd        = CMD_FREE;
		req_ch.object_key = '0;
		rsp_ch.ready      = 1'b0;
		for (int i = 0; i < N_SLOTS; i++) begin
			slot_used[i]  = 1'b0;
			slot_key[i]   = '0;
			slot_state[i] = ST_ALLOC;
		end

		// Directed: key zero to error through a double free, error stays error
		add_event(CMD_MALLOC, 32'h0000_0000);
		add_event(CMD_FREE,   32'h0000_0000);
		add_event(CMD_FREE,   32'h0000_0000);
		add_event(CMD_MALLOC, 32'h0000_0000);
		add_event(CMD_FREE,   32'h0000_0000);
		// Free of an untracked key inserts it as allocated
		add_event(CMD_FREE,   32'hFFFF_FFFF);
		add_event(CMD_MALLOC, 32'hFFFF_FFFF);
		add_event(CMD_FREE,   32'hFFFF_FFFF);
		add_event(CMD_MALLOC, 32'hFFFF_FFFF);
		add_event(CMD_FREE,   32'hFFFF_FFFF);
		add_event(CMD_FREE,   32'hFFFF_FFFF);
		add_event(CMD_MALLOC, 32'hFFFF_FFFF);
		// Keys one bit apart from tracked ones must not hit
		add_event(CMD_FREE,   32'h8000_0000);
		add_event(CMD_MALLOC, 32'h0000_0001);
		add_event(CMD_FREE,   32'h7FFF_FFFF);
		add_event(CMD_FREE,   32'h0000_0001);
		add_event(CMD_FREE,   32'hFFFF_FFFE);

		// Random: pool keys in malloc/free pairs with some noise,
		// then fresh keys mixed in until the table overflows
		for (int i = 0; i < POOL_KEYS; i++) begin
			pool_key[i]  = $urandom();
			pool_last[i] = CMD_FREE;
		end
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n >= N_POOL_ONLY && $urandom_range(99) < 25) begin
				add_event(1'($urandom_range(1)), $urandom());
			end else begin
				idx = $urandom_range(POOL_KEYS - 1);
				if ($urandom_range(99) < 12)
					cmd = 1'($urandom_range(1));
				else
					cmd = (pool_last[idx] == CMD_FREE) ? CMD_MALLOC : CMD_FREE;
				pool_last[idx] = cmd;
				add_event(cmd, pool_key[idx]);
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Drain: all items accepted, all results back, then a short tail
		while (pending_events.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (expected_reports.size() != 0)
			flag_error("events left without a result");

		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
